FILE: rtl/core/ses_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Segment execution supervisor package
// Shared types, codes, register limits and the saturating tick helper.
// ----------------------------------------------------------------------------
package ses_pkg;

  localparam int TICK_W = 16;
  localparam int CFG_W  = 16;
  localparam int CMP_W  = (TICK_W > CFG_W) ? TICK_W : CFG_W;

  typedef logic [TICK_W-1:0] tick_t;
  typedef logic [CFG_W-1:0]  cfg_word_t;

  localparam tick_t TICK_MAX = {TICK_W{1'b1}};

  typedef enum logic [2:0] {
    CFG_RUN_TIMEOUT  = 3'd0,
    CFG_HOLD_TIMEOUT = 3'd1,
    CFG_ACCEPT       = 3'd2,
    CFG_REPUBLISH    = 3'd3,
    CFG_FEEDBACK     = 3'd4
  } cfg_idx_t;

  localparam cfg_word_t RUN_TIMEOUT_LOW    = CFG_W'(20);
  localparam cfg_word_t HOLD_TIMEOUT_LOW   = CFG_W'(2);
  localparam cfg_word_t ACCEPT_LOW         = CFG_W'(4);
  localparam cfg_word_t REPUBLISH_LOW      = CFG_W'(2);
  localparam cfg_word_t FEEDBACK_LOW       = CFG_W'(4);

  localparam cfg_word_t RUN_TIMEOUT_RST    = CFG_W'(1200);
  localparam cfg_word_t HOLD_TIMEOUT_RST   = CFG_W'(60);
  localparam cfg_word_t ACCEPT_RST         = CFG_W'(40);
  localparam cfg_word_t REPUBLISH_RST      = CFG_W'(10);
  localparam cfg_word_t FEEDBACK_RST       = CFG_W'(20);

  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_TICK  = 1'b1;

  localparam logic [2:0] ST_PASS   = 3'd0;
  localparam logic [2:0] ST_HOLD   = 3'd1;
  localparam logic [2:0] ST_REPLAN = 3'd2;
  localparam logic [2:0] ST_ABORT  = 3'd3;

  typedef enum logic [1:0] {
    OC_RUN    = 2'd0,
    OC_OK     = 2'd1,
    OC_FAIL   = 2'd2,
    OC_REPLAN = 2'd3
  } outcome_t;

  typedef enum logic [3:0] {
    RC_NONE        = 4'd0,
    RC_MODE        = 4'd1,
    RC_EMPTY       = 4'd2,
    RC_CANCEL      = 4'd3,
    RC_RUN_TIMEOUT = 4'd4,
    RC_NO_FEEDBACK = 4'd5,
    RC_STALE       = 4'd6,
    RC_HOLD        = 4'd7,
    RC_REPLAN      = 4'd8,
    RC_ABORT       = 4'd9,
    RC_IDLE        = 4'd10
  } reason_t;

  typedef struct packed {
    logic       func;
    logic       mode_failed;
    logic       path_empty;
    logic       cancel_flag;
    logic       report_valid;
    logic [2:0] report_status;
    logic       report_terminal;
  } in_item_t;

  typedef struct packed {
    outcome_t outcome;
    reason_t  reason_code;
    logic     publish_request;
  } out_item_t;

  typedef struct packed {
    cfg_word_t run_timeout_ticks;
    cfg_word_t hold_timeout_ticks;
    cfg_word_t accept_timeout_ticks;
    cfg_word_t republish_ticks;
    cfg_word_t feedback_timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic  active;
    tick_t elapsed_ticks;
    tick_t since_publish;
    tick_t since_report;
    tick_t hold_ticks;
    logic  holding;
    logic  got_report;
  } sup_state_t;

  // Saturating increment of a tick counter.
  function automatic tick_t bump(input tick_t v);
    bump = (v == TICK_MAX) ? TICK_MAX : v + TICK_W'(1);
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/ses_cfg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Supervisor configuration registers
// Five timeout registers; writes below the lower limit are raised to it.
// ----------------------------------------------------------------------------
module ses_cfg (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_we,
  input  wire logic [2:0]          cfg_index,
  input  wire ses_pkg::cfg_word_t  cfg_data,
  output ses_pkg::cfg_t            cfg_o
);
  import ses_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  function automatic cfg_word_t clamp(input cfg_word_t v, input cfg_word_t low);
    clamp = (v < low) ? low : v;
  endfunction

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_RUN_TIMEOUT:  cfg_nxt.run_timeout_ticks =
                              clamp(cfg_data, RUN_TIMEOUT_LOW);
        CFG_HOLD_TIMEOUT: cfg_nxt.hold_timeout_ticks =
                              clamp(cfg_data, HOLD_TIMEOUT_LOW);
        CFG_ACCEPT:       cfg_nxt.accept_timeout_ticks =
                              clamp(cfg_data, ACCEPT_LOW);
        CFG_REPUBLISH:    cfg_nxt.republish_ticks =
                              clamp(cfg_data, REPUBLISH_LOW);
        CFG_FEEDBACK:     cfg_nxt.feedback_timeout_ticks =
                              clamp(cfg_data, FEEDBACK_LOW);
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.run_timeout_ticks      <= RUN_TIMEOUT_RST;
      cfg_r.hold_timeout_ticks     <= HOLD_TIMEOUT_RST;
      cfg_r.accept_timeout_ticks   <= ACCEPT_RST;
      cfg_r.republish_ticks        <= REPUBLISH_RST;
      cfg_r.feedback_timeout_ticks <= FEEDBACK_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg_o = cfg_r;

endmodule
`default_nettype wire

FILE: rtl/core/ses_rule.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Supervisor decision rule
// One supervision pass: result and next state from item, state and config.
// ----------------------------------------------------------------------------
module ses_rule (
  input  wire ses_pkg::in_item_t   item,
  input  wire ses_pkg::sup_state_t st,
  input  wire ses_pkg::cfg_t       cfg,
  output ses_pkg::out_item_t       res,
  output ses_pkg::sup_state_t      st_nxt
);
  import ses_pkg::*;

  logic  pub;
  logic  hold_rep;
  logic  done;
  tick_t hold_eff;

  function automatic logic gt(input tick_t a, input cfg_word_t b);
    gt = CMP_W'(a) > CMP_W'(b);
  endfunction

  always_comb begin
    st_nxt   = st;
    res      = '{outcome: OC_RUN, reason_code: RC_NONE, publish_request: 1'b0};
    pub      = 1'b0;
    done     = 1'b0;
    hold_rep = item.report_valid && (item.report_status == ST_HOLD)
               && !item.report_terminal;
    hold_eff = st.holding ? st.hold_ticks : '0;

    if (item.func == FUNC_START) begin
      st_nxt.active = 1'b0;
      if (item.mode_failed) begin
        res.outcome     = OC_FAIL;
        res.reason_code = RC_MODE;
      end else if (item.path_empty) begin
        res.outcome     = OC_FAIL;
        res.reason_code = RC_EMPTY;
      end else begin
        st_nxt              = '0;
        st_nxt.active       = 1'b1;
        res.publish_request = 1'b1;
      end
    end else if (!st.active) begin
      res.reason_code = RC_IDLE;
    end else if (item.cancel_flag) begin
      st_nxt.active   = 1'b0;
      res.outcome     = OC_FAIL;
      res.reason_code = RC_CANCEL;
    end else if (gt(st.elapsed_ticks, cfg.run_timeout_ticks)) begin
      st_nxt.active   = 1'b0;
      res.outcome     = OC_REPLAN;
      res.reason_code = RC_RUN_TIMEOUT;
    end else begin
      // Republish is due while still unacknowledged; it rides along with
      // whatever else this pass decides.
      pub = !st.got_report &&
            (CMP_W'(st.since_publish) >= CMP_W'(cfg.republish_ticks));
      res.publish_request = pub;
      if (pub) st_nxt.since_publish = '0;
      done = 1'b1;

      if (!st.got_report && gt(st.elapsed_ticks, cfg.accept_timeout_ticks)) begin
        res.outcome     = OC_FAIL;
        res.reason_code = RC_NO_FEEDBACK;
      end else if (st.got_report &&
                   gt(st.since_report, cfg.feedback_timeout_ticks)) begin
        res.outcome     = OC_FAIL;
        res.reason_code = RC_STALE;
      end else if (item.report_valid && hold_rep &&
                   gt(hold_eff, cfg.hold_timeout_ticks)) begin
        res.outcome     = OC_REPLAN;
        res.reason_code = RC_HOLD;
      end else if (item.report_valid && !item.report_terminal &&
                   item.report_status == ST_REPLAN) begin
        res.outcome     = OC_REPLAN;
        res.reason_code = RC_REPLAN;
      end else if (item.report_valid && !item.report_terminal &&
                   item.report_status == ST_ABORT) begin
        res.outcome     = OC_FAIL;
        res.reason_code = RC_ABORT;
      end else if (item.report_valid && item.report_terminal) begin
        if (item.report_status == ST_PASS) begin
          res.outcome     = OC_OK;
          res.reason_code = RC_NONE;
        end else if (item.report_status == ST_REPLAN ||
                     item.report_status == ST_HOLD) begin
          res.outcome     = OC_REPLAN;
          res.reason_code = RC_REPLAN;
        end else begin
          res.outcome     = OC_FAIL;
          res.reason_code = RC_ABORT;
        end
      end else begin
        done = 1'b0;
      end

      if (done) begin
        st_nxt.active = 1'b0;
      end else begin
        // Execution keeps running: apply the report, then advance the timers.
        st_nxt.elapsed_ticks = bump(st.elapsed_ticks);
        st_nxt.since_publish = bump(pub ? '0 : st.since_publish);
        if (item.report_valid) begin
          st_nxt.got_report   = 1'b1;
          st_nxt.since_report = bump('0);
          st_nxt.holding      = hold_rep;
          st_nxt.hold_ticks   = hold_rep ? bump(hold_eff) : '0;
        end else begin
          st_nxt.since_report = bump(st.since_report);
          st_nxt.hold_ticks   = st.holding ? bump(st.hold_ticks) : st.hold_ticks;
        end
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/segment_execution_supervisor.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Segment execution supervisor
// Supervises one path-segment execution counted in poll ticks.
// ----------------------------------------------------------------------------
// Usage: each request on the in_ channel is either a start (func = 0) or one
// poll tick (func = 1). Every request yields exactly one result request on the
// out_ channel carrying the outcome, a reason code and a publish pulse.
// A request is taken at a rising edge with in_valid high and in_stall low; a
// result is taken at an edge with out_valid high and out_stall low.
// The request is captured in an input register, the decision rule runs on it
// combinationally and its result lands in the output register, which drives
// out_valid; the result is taken once out_stall is low. Throughput is one
// request per cycle while the receiver does not stall; the single pass through
// the rule and the state registers sets it.
// When the receiver stalls, the output register holds its result and the
// input register still takes one more request; in_stall rises only when both
// registers are full and the result is stalled.
// The cfg_ port writes the five timeout registers (always ready); write only
// while no request is in flight. Reset restores register defaults, makes the
// supervisor idle and empties both pipeline registers.
// ----------------------------------------------------------------------------
module segment_execution_supervisor (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire ses_pkg::in_item_t   in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output ses_pkg::out_item_t       out_data,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [2:0]          cfg_index,
  input  wire ses_pkg::cfg_word_t  cfg_data
);
  import ses_pkg::*;

  cfg_t       cfg;
  sup_state_t st_r;
  sup_state_t st_nxt;
  out_item_t  res;

  logic       s1_valid_r;
  in_item_t   s1_data_r;
  logic       out_valid_r;
  out_item_t  out_data_r;

  logic       advance;
  logic       in_fire;

  // The output register can take a new result when empty or being drained.
  assign advance   = !out_valid_r || !out_stall;
  assign in_stall  = s1_valid_r && !advance;
  assign in_fire   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  ses_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_o     (cfg)
  );

  ses_rule u_rule (
    .item   (s1_data_r),
    .st     (st_r),
    .cfg    (cfg),
    .res    (res),
    .st_nxt (st_nxt)
  );

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_data_r <= in_data;
    end
  end

  // Supervision state and output register move together with each pass.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= '0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
      if (s1_valid_r) begin
        st_r <= st_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid_r) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A pass that ends the execution leaves the supervisor idle.
  a_end_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && s1_valid_r && res.outcome != OC_RUN) |=> !st_r.active)
    else $error("supervisor still active after a final outcome");

  // A publish pulse is only raised before the first follower report.
  a_pub_unacked: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && s1_valid_r && res.publish_request &&
     s1_data_r.func == FUNC_TICK) |-> !st_r.got_report)
    else $error("republish after a follower report");

  // Only a start can bring the supervisor from idle to active.
  a_rise_on_start: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(st_r.active) |-> $past(s1_data_r.func == FUNC_START))
    else $error("supervisor activated without a start");

  // Back-pressure reaches the input only with both registers occupied.
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r && out_stall))
    else $error("input stalled with room in the pipeline");

endmodule
`default_nettype wire

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment execution supervisor testbench
// Drives start and poll-tick requests into the supervisor under random sender
// bursts and receiver stalls, predicts every outcome with an independent model
// of the supervision rule, and checks each result field by field.
// ----------------------------------------------------------------------------
module tb_top;
  import ses_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned SETTLE_CYCLES  = 4;
  localparam int unsigned SOAK_TICKS     = 150;
  localparam int unsigned PHASE_ITEMS    = 400;

  // Status codes above abort have no name in the package; the block treats
  // them all as "other".
  localparam logic [2:0] ST_OTHER    = 3'd4;
  localparam logic [2:0] ST_SPARE_LO = 3'd5;
  localparam logic [2:0] ST_SPARE_HI = 3'd7;

  // An index past the last register; a write there must change nothing.
  localparam logic [2:0] CFG_UNUSED_IDX = 3'd7;

  // Flavors of a random execution. Each one steers the follower reports so
  // that a different ending becomes likely.
  typedef enum int unsigned {
    STYLE_SILENT,   // no reports at all: republish pulses, acceptance timeout
    STYLE_STEADY,   // reports nearly every tick: run timeout
    STYLE_SPARSE,   // rare reports: feedback staleness
    STYLE_HOLDING,  // mostly hold reports: hold timer
    STYLE_MIXED     // frequent terminal reports: status decisions
  } session_style_t;

  typedef enum int unsigned {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_SOLID
  } stall_mode_t;

  // --------------------------------------------------------------------------
  // Outcome tracker: holds its own copy of the registers and the supervision
  // state, works out the result of every accepted request and keeps the
  // results still owed by the block in order.
  // --------------------------------------------------------------------------
  class outcome_tracker;
    cfg_word_t   run_limit;
    cfg_word_t   hold_limit;
    cfg_word_t   accept_limit;
    cfg_word_t   republish_period;
    cfg_word_t   feedback_limit;
    logic        running;
    logic        holding;
    logic        heard;
    tick_t       elapsed;
    tick_t       since_pub;
    tick_t       since_rep;
    tick_t       hold_count;
    out_item_t   expected_q[$];
    int unsigned errors;
    int unsigned starts;
    int unsigned ticks;
    int unsigned results;
    int unsigned reason_hits[11];

    function new();
      run_limit        = RUN_TIMEOUT_RST;
      hold_limit       = HOLD_TIMEOUT_RST;
      accept_limit     = ACCEPT_RST;
      republish_period = REPUBLISH_RST;
      feedback_limit   = FEEDBACK_RST;
      running    = 1'b0;
      holding    = 1'b0;
      heard      = 1'b0;
      elapsed    = '0;
      since_pub  = '0;
      since_rep  = '0;
      hold_count = '0;
      errors  = 0;
      starts  = 0;
      ticks   = 0;
      results = 0;
      foreach (reason_hits[i]) reason_hits[i] = 0;
    endfunction

    // Register writes below the lower bound are raised to it.
    function void set_register(input logic [2:0] idx, input cfg_word_t v);
      case (idx)
        CFG_RUN_TIMEOUT:  run_limit        = (v < RUN_TIMEOUT_LOW) ? RUN_TIMEOUT_LOW : v;
        CFG_HOLD_TIMEOUT: hold_limit       = (v < HOLD_TIMEOUT_LOW) ? HOLD_TIMEOUT_LOW : v;
        CFG_ACCEPT:       accept_limit     = (v < ACCEPT_LOW) ? ACCEPT_LOW : v;
        CFG_REPUBLISH:    republish_period = (v < REPUBLISH_LOW) ? REPUBLISH_LOW : v;
        CFG_FEEDBACK:     feedback_limit   = (v < FEEDBACK_LOW) ? FEEDBACK_LOW : v;
        default: ;
      endcase
    endfunction

    function tick_t sat_inc(input tick_t v);
      return (&v) ? v : v + 1'b1;
    endfunction

    function out_item_t result_of(input outcome_t oc, input reason_t rc, input logic pub);
      out_item_t r;
      r.outcome         = oc;
      r.reason_code     = rc;
      r.publish_request = pub;
      return r;
    endfunction

    // One pass of the supervision rule. Updates the state and returns the
    // result that the request must produce.
    function out_item_t next_outcome(input in_item_t req);
      logic       pub;
      logic [2:0] st;
      logic       term;
      pub  = 1'b0;
      st   = req.report_status;
      term = req.report_terminal;

      if (req.func == FUNC_START) begin
        running = 1'b0;
        if (req.mode_failed) return result_of(OC_FAIL, RC_MODE, 1'b0);
        if (req.path_empty) return result_of(OC_FAIL, RC_EMPTY, 1'b0);
        running    = 1'b1;
        elapsed    = '0;
        since_pub  = '0;
        since_rep  = '0;
        hold_count = '0;
        holding    = 1'b0;
        heard      = 1'b0;
        return result_of(OC_RUN, RC_NONE, 1'b1);
      end

      if (!running) return result_of(OC_RUN, RC_IDLE, 1'b0);

      if (req.cancel_flag) begin
        running = 1'b0;
        return result_of(OC_FAIL, RC_CANCEL, 1'b0);
      end
      if (elapsed > run_limit) begin
        running = 1'b0;
        return result_of(OC_REPLAN, RC_RUN_TIMEOUT, 1'b0);
      end
      // The republish pulse is decided after the cancel and run-timeout checks
      // but before the other endings, so it survives any of those on the same pass.
      if (!heard && since_pub >= republish_period) begin
        pub       = 1'b1;
        since_pub = '0;
      end
      if (!heard && elapsed > accept_limit) begin
        running = 1'b0;
        return result_of(OC_FAIL, RC_NO_FEEDBACK, pub);
      end
      if (heard && since_rep > feedback_limit) begin
        running = 1'b0;
        return result_of(OC_FAIL, RC_STALE, pub);
      end

      if (req.report_valid) begin
        heard     = 1'b1;
        since_rep = '0;
        if (st == ST_HOLD && !term) begin
          if (!holding) begin
            holding    = 1'b1;
            hold_count = '0;
          end
          if (hold_count > hold_limit) begin
            running = 1'b0;
            return result_of(OC_REPLAN, RC_HOLD, pub);
          end
        end else begin
          holding    = 1'b0;
          hold_count = '0;
        end

        if (term) begin
          running = 1'b0;
          if (st == ST_PASS) return result_of(OC_OK, RC_NONE, pub);
          if (st == ST_REPLAN || st == ST_HOLD) return result_of(OC_REPLAN, RC_REPLAN, pub);
          return result_of(OC_FAIL, RC_ABORT, pub);
        end
        if (st == ST_REPLAN) begin
          running = 1'b0;
          return result_of(OC_REPLAN, RC_REPLAN, pub);
        end
        if (st == ST_ABORT) begin
          running = 1'b0;
          return result_of(OC_FAIL, RC_ABORT, pub);
        end
      end

      elapsed   = sat_inc(elapsed);
      since_pub = sat_inc(since_pub);
      since_rep = sat_inc(since_rep);
      if (holding) hold_count = sat_inc(hold_count);
      return result_of(OC_RUN, RC_NONE, pub);
    endfunction

    function void note_request(input in_item_t req);
      if (req.func == FUNC_START) starts++;
      else ticks++;
      expected_q.insert(expected_q.size(), next_outcome(req));
    endfunction

    function void check_result(input out_item_t got);
      out_item_t want;
      results++;
      if (expected_q.size() == 0) begin
        errors++;
        $error("result with no request waiting: outcome %0d reason %0d publish %0d",
               got.outcome, got.reason_code, got.publish_request);
        return;
      end
      want = expected_q.pop_front();
      reason_hits[want.reason_code]++;
      if (got.outcome !== want.outcome) begin
        errors++;
        $error("outcome: expected %0d, actual %0d", want.outcome, got.outcome);
      end
      if (got.reason_code !== want.reason_code) begin
        errors++;
        $error("reason_code: expected %0d, actual %0d", want.reason_code, got.reason_code);
      end
      if (got.publish_request !== want.publish_request) begin
        errors++;
        $error("publish_request: expected %0d, actual %0d",
               want.publish_request, got.publish_request);
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and the block itself. Every input starts at a known value.
  // --------------------------------------------------------------------------
  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  in_item_t    in_data   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  cfg_word_t   cfg_data  = '0;

  always #10 clk = ~clk;

  segment_execution_supervisor i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  outcome_tracker tracker;

  int unsigned burst_left    = 0;
  int unsigned session_items = 0;
  int unsigned quiet_cycles  = 0;
  stall_mode_t stall_mode    = STALL_NONE;
  int unsigned stall_left    = 0;

  // --------------------------------------------------------------------------
  // Receiver. The stall line follows a pattern of its own: it picks a mode
  // at random and keeps it for a randomly drawn stretch, from never stalling
  // through stalling at random to stalling solidly, which backs the pipeline
  // up until the block raises in_stall.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= stall_mode_t'($urandom_range(0, 3));
      stall_left <= $urandom_range(8, 60);
      out_stall  <= 1'b0;
    end else begin
      stall_left <= stall_left - 1;
      case (stall_mode)
        STALL_NONE:  out_stall <= 1'b0;
        STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default:     out_stall <= 1'b1;
      endcase
    end
  end

  // Every result taken by the receiver is checked against the oldest
  // outstanding prediction. A result passes through the input and the output
  // register after its request is accepted, so the prediction is always queued first.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) tracker.check_result(out_data);
  end

  // The watchdog counts cycles in which no handshake of any kind completes.
  // A hung block or a lost result ends the run here.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sender. Requests go out in bursts of random length separated by random
  // gaps; some bursts are long so that stretches without any idling occur.
  // The task returns at the edge where its request was accepted and leaves
  // in_valid high, so a following request in the same burst keeps valid up
  // without a drop.
  // --------------------------------------------------------------------------
  task automatic send_request(input in_item_t req);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(80, 200)
                                               : $urandom_range(1, 30);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.note_request(req);
  endtask

  // Stops sending and waits until every predicted result has come back, then
  // lets the block settle before returning.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes all five registers back to back, then one write to an index past
  // the register list, which must have no effect. Only called while no
  // request is in flight.
  task automatic program_registers(input cfg_word_t run_v, input cfg_word_t hold_v,
                                   input cfg_word_t accept_v, input cfg_word_t repub_v,
                                   input cfg_word_t fb_v);
    cfg_word_t values [5];
    values[0] = run_v;
    values[1] = hold_v;
    values[2] = accept_v;
    values[3] = repub_v;
    values[4] = fb_v;
    cfg_valid <= 1'b1;
    for (int i = 0; i < 6; i++) begin
      if (i < 5) begin
        cfg_index <= cfg_idx_t'(i);
        cfg_data  <= values[i];
      end else begin
        cfg_index <= CFG_UNUSED_IDX;
        cfg_data  <= cfg_word_t'($urandom);
      end
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      if (i < 5) tracker.set_register(cfg_idx_t'(i), values[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Request builders. Directed requests clear the fields a request ignores;
  // random ones leave those fields random so every bit toggles.
  // --------------------------------------------------------------------------
  function automatic in_item_t start_req(input logic mf, input logic pe);
    in_item_t r;
    r             = '0;
    r.func        = FUNC_START;
    r.mode_failed = mf;
    r.path_empty  = pe;
    return r;
  endfunction

  function automatic in_item_t tick_req(input logic cancel, input logic rv,
                                        input logic [2:0] st, input logic term);
    in_item_t r;
    r                 = '0;
    r.func            = FUNC_TICK;
    r.cancel_flag     = cancel;
    r.report_valid    = rv;
    r.report_status   = st;
    r.report_terminal = term;
    return r;
  endfunction

  function automatic in_item_t noise_item();
    logic [31:0] raw;
    raw = $urandom;
    return in_item_t'(raw[$bits(in_item_t)-1:0]);
  endfunction

  // A start that mostly succeeds; about one in six fails on the mode request
  // or the empty path.
  function automatic in_item_t random_start();
    in_item_t r;
    r             = noise_item();
    r.func        = FUNC_START;
    r.mode_failed = ($urandom_range(0, 11) == 0);
    r.path_empty  = ($urandom_range(0, 11) == 0);
    return r;
  endfunction

  function automatic in_item_t random_tick(input session_style_t style);
    in_item_t    r;
    int unsigned pick;
    r             = noise_item();
    r.func        = FUNC_TICK;
    r.cancel_flag = ($urandom_range(0, 59) == 0);
    case (style)
      STYLE_SILENT:  r.report_valid = 1'b0;
      STYLE_STEADY:  r.report_valid = ($urandom_range(0, 9) != 0);
      STYLE_SPARSE:  r.report_valid = ($urandom_range(0, 3) == 0);
      STYLE_HOLDING: r.report_valid = ($urandom_range(0, 9) < 7);
      default:       r.report_valid = ($urandom_range(0, 1) == 0);
    endcase
    if (r.report_valid) begin
      pick = $urandom_range(0, 9);
      // Calm reports (pass or the "other" codes) keep the execution going;
      // the rest are fully random codes.
      if (style == STYLE_HOLDING && pick < 8) r.report_status = ST_HOLD;
      else if (pick < 7) r.report_status = ($urandom_range(0, 1) == 0) ? ST_PASS
                                           : 3'($urandom_range(ST_OTHER, ST_SPARE_HI));
      r.report_terminal = (style == STYLE_MIXED) ? ($urandom_range(0, 7) == 0)
                                                 : ($urandom_range(0, 39) == 0);
    end
    return r;
  endfunction

  // One execution from its start until it ends, with an occasional restart
  // in the middle. A cap keeps long-timeout settings from running forever.
  task automatic run_session(input session_style_t style);
    int unsigned n;
    n = 0;
    send_request(random_start());
    session_items++;
    while (tracker.running && n < 300) begin
      if ($urandom_range(0, 149) == 0) send_request(random_start());
      else send_request(random_tick(style));
      session_items++;
      n++;
    end
  endtask

  // Mostly well-formed executions; between them a little noise (ticks while
  // idle and random starts) and now and then a full pause until every
  // result is back.
  task automatic random_phase(input int unsigned budget);
    int unsigned target;
    target = session_items + budget;
    while (session_items < target) begin
      run_session(session_style_t'($urandom_range(0, 4)));
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 3)) send_request(noise_item());
      end
      if ($urandom_range(0, 39) == 0) wait_for_results();
    end
  endtask

  // --------------------------------------------------------------------------
  // Test sequence.
  // --------------------------------------------------------------------------
  initial begin
    tracker = new();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part under the reset register values. A tick while idle with
    // every tick field set must be ignored.
    send_request(tick_req(1'b1, 1'b1, ST_SPARE_HI, 1'b1));
    // A failed mode request wins over an empty path.
    send_request(start_req(1'b1, 1'b1));
    send_request(start_req(1'b0, 1'b1));
    // A start while an execution is running drops it and begins anew.
    send_request(start_req(1'b0, 1'b0));
    send_request(start_req(1'b0, 1'b0));
    // Non-terminal reports that keep the execution running, including the
    // undefined status codes.
    send_request(tick_req(1'b0, 1'b1, ST_PASS, 1'b0));
    send_request(tick_req(1'b0, 1'b1, ST_OTHER, 1'b0));
    send_request(tick_req(1'b0, 1'b1, ST_SPARE_HI, 1'b0));
    send_request(tick_req(1'b0, 1'b1, ST_HOLD, 1'b0));
    send_request(tick_req(1'b0, 1'b0, ST_PASS, 1'b0));
    // Cancel beats a terminal pass report on the same tick.
    send_request(tick_req(1'b1, 1'b1, ST_PASS, 1'b1));
    // Each terminal status, then the non-terminal replan and abort.
    send_request(start_req(1'b0, 1'b0));
    send_request(tick_req(1'b0, 1'b1, ST_PASS, 1'b1));
    send_request(start_req(1'b0, 1'b0));
    send_request(tick_req(1'b0, 1'b1, ST_HOLD, 1'b1));
    send_request(start_req(1'b0, 1'b0));
    send_request(tick_req(1'b0, 1'b1, ST_REPLAN, 1'b1));
    send_request(start_req(1'b0, 1'b0));
    send_request(tick_req(1'b0, 1'b1, ST_ABORT, 1'b1));
    send_request(start_req(1'b0, 1'b0));
    send_request(tick_req(1'b0, 1'b1, ST_SPARE_LO, 1'b1));
    send_request(start_req(1'b0, 1'b0));
    send_request(tick_req(1'b0, 1'b1, ST_REPLAN, 1'b0));
    send_request(start_req(1'b0, 1'b0));
    send_request(tick_req(1'b0, 1'b1, ST_ABORT, 1'b0));
    wait_for_results();

    // Every register written below its lower bound, so all sit at the
    // smallest legal value and every timeout fires quickly.
    program_registers('0, '0, '0, '0, '0);
    random_phase(PHASE_ITEMS);
    wait_for_results();

    // Two random settings of short timeouts; in the first, values below the
    // bounds are possible and get raised.
    program_registers(cfg_word_t'($urandom_range(0, 80)), cfg_word_t'($urandom_range(0, 12)),
                      cfg_word_t'($urandom_range(0, 20)), cfg_word_t'($urandom_range(0, 10)),
                      cfg_word_t'($urandom_range(0, 16)));
    random_phase(PHASE_ITEMS);
    wait_for_results();

    program_registers(cfg_word_t'($urandom_range(20, 120)), cfg_word_t'($urandom_range(2, 20)),
                      cfg_word_t'($urandom_range(4, 40)), cfg_word_t'($urandom_range(2, 16)),
                      cfg_word_t'($urandom_range(4, 24)));
    random_phase(PHASE_ITEMS);
    wait_for_results();

    // Every register at its maximum. One long execution runs first without
    // reports and then with hold reports; no timeout and no republish may
    // fire at this setting.
    program_registers('1, '1, '1, '1, '1);
    send_request(start_req(1'b0, 1'b0));
    repeat (SOAK_TICKS) send_request(tick_req(1'b0, 1'b0, ST_PASS, 1'b0));
    repeat (SOAK_TICKS) begin
      send_request(tick_req(1'b0, ($urandom_range(0, 1) == 0), ST_HOLD, 1'b0));
    end
    wait_for_results();
    repeat (10) @(posedge clk);

    $display("Covered %0d starts and %0d ticks over five register settings, %0d results.",
             tracker.starts, tracker.ticks, tracker.results);
    $display("Results by reason, none to idle: %0d %0d %0d %0d %0d %0d %0d %0d %0d %0d %0d",
             tracker.reason_hits[0], tracker.reason_hits[1], tracker.reason_hits[2],
             tracker.reason_hits[3], tracker.reason_hits[4], tracker.reason_hits[5],
             tracker.reason_hits[6], tracker.reason_hits[7], tracker.reason_hits[8],
             tracker.reason_hits[9], tracker.reason_hits[10]);
    if (tracker.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/ses_pkg.sv
rtl/core/ses_cfg.sv
rtl/core/ses_rule.sv
rtl/core/segment_execution_supervisor.sv
tb/tb_top.sv
